[hdl/lkv_pkg.sv]
// Shared types and constants for the LRU key/value cache.
// Holds the request codes, controller states and the control/status structs.
// No dependencies.
`default_nettype none

package lkv_pkg;

   // Fixed field widths
   localparam int CAP_BITS   = 5;
   localparam int COUNT_BITS = 32;

   // Capacity after reset
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   // Counter saturation value
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Register index, taken from paddr bit 2
   localparam logic CSR_CAPACITY = 1'b0;

   // Request kinds
   typedef enum logic [1:0] {
      MODE_GET   = 2'd0,
      MODE_PUT   = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;   // load the request register
      logic lookup;    // register match, victim and free slot results
      logic commit;    // update entries and load the result register
   } lkv_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic rsp_busy;  // result register full and stalled
   } lkv_status_type;

endpackage

`default_nettype wire

[hdl/lkv_ctrl.sv]
// Controller state machine for the LRU key/value cache.
// Sequences capture, lookup and update; depends on lkv_pkg.
`default_nettype none

module lkv_ctrl
   import lkv_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire lkv_status_type status,
   output lkv_cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.lookup  = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            // finish once the result register can take the item
            if (!status.rsp_busy) begin
               cmd.commit = 1'b1;
               req_stall  = 1'b0;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_LOOKUP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[hdl/lkv_datapath.sv]
// Datapath for the LRU key/value cache: entry registers, value memory,
// lookup results, age update, counters and the result register. Uses lkv_pkg.
`default_nettype none

module lkv_datapath
   import lkv_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lkv_cmd_type           cmd,
   output lkv_status_type             status,
   input  wire logic [1:0]            req_mode,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [VALUE_BITS-1:0] req_value,
   input  wire logic [CAP_BITS-1:0]   capacity,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_hit,
   output logic [VALUE_BITS-1:0]      rsp_read_value,
   output logic                       rsp_evicted,
   output logic [COUNT_BITS-1:0]      rsp_hit_total,
   output logic [COUNT_BITS-1:0]      rsp_miss_total
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int AGE_W = IDX_W;
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;

   // Request register
   logic [1:0]            mode_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;

   // Entry state
   logic [KEY_BITS-1:0]   keys_ff [ENTRIES];
   logic [VALUE_BITS-1:0] mem_values [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [AGE_W-1:0]      age_ff [ENTRIES];
   logic [AGE_W-1:0]      age_in [ENTRIES];
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [COUNT_BITS-1:0] hits_ff, hits_in;
   logic [COUNT_BITS-1:0] misses_ff, misses_in;

   // Lookup results
   logic                  hit_ff;
   logic [IDX_W-1:0]      hit_slot_ff;
   logic [AGE_W-1:0]      hit_age_ff;
   logic                  evict_ff;
   logic [IDX_W-1:0]      old_slot_ff;
   logic                  ins_ok_ff;
   logic [IDX_W-1:0]      ins_slot_ff;
   logic [VALUE_BITS-1:0] rd_data_ff;

   // Result register
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [VALUE_BITS-1:0] rsp_read_value_ff;
   logic                  rsp_evicted_ff;
   logic [COUNT_BITS-1:0] rsp_hit_total_ff;
   logic [COUNT_BITS-1:0] rsp_miss_total_ff;

   // Lookup logic
   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] old_vec;
   logic [ENTRIES-1:0] free_vec;
   logic [IDX_W-1:0]   hit_slot;
   logic [IDX_W-1:0]   old_slot;
   logic [IDX_W-1:0]   ins_slot;
   logic [AGE_W-1:0]   oldest_age;
   logic [CMP_W-1:0]   cap_ext;
   logic [CMP_W-1:0]   eff_cap;
   logic               evict;

   // Update logic
   logic               key_wr;
   logic               mem_wr;
   logic [IDX_W-1:0]   mem_addr;

   // Request register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
   end

   // Parallel key compare; the oldest valid entry has age occupancy-1
   assign oldest_age = AGE_W'(occ_ff - OCC_W'(1));

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]   = valid_ff[i] && (keys_ff[i] == key_ff);
         old_vec[i] = valid_ff[i] && (age_ff[i] == oldest_age);
      end
   end

   // Effective capacity, clamped to 1..ENTRIES
   always_comb begin
      cap_ext = CMP_W'(capacity);
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign evict = (mode_ff == MODE_PUT) && !(|match) &&
                  (CMP_W'(occ_ff) >= eff_cap) && (occ_ff != '0);

   // Slots left free once the victim is gone
   assign free_vec = ~(valid_ff & ~(evict ? old_vec : '0));

   // Lowest-index encoders
   always_comb begin
      hit_slot = '0;
      old_slot = '0;
      ins_slot = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) hit_slot = IDX_W'(i);
         if (old_vec[i]) old_slot = IDX_W'(i);
         if (free_vec[i]) ins_slot = IDX_W'(i);
      end
   end

   // Lookup result registers
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff      <= |match;
         hit_slot_ff <= hit_slot;
         hit_age_ff  <= age_ff[hit_slot];
         evict_ff    <= evict;
         old_slot_ff <= old_slot;
         ins_ok_ff   <= |free_vec;
         ins_slot_ff <= ins_slot;
      end
   end

   // Entry update
   always_comb begin
      valid_in  = valid_ff;
      age_in    = age_ff;
      occ_in    = occ_ff;
      hits_in   = hits_ff;
      misses_in = misses_ff;
      key_wr    = 1'b0;
      mem_wr    = 1'b0;
      mem_addr  = hit_slot_ff;
      case (mode_type'(mode_ff))
         MODE_GET: begin
            if (hit_ff) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_ff[i] && (age_ff[i] < hit_age_ff)) begin
                     age_in[i] = age_ff[i] + AGE_W'(1);
                  end
               end
               age_in[hit_slot_ff] = '0;
               if (hits_ff != COUNT_MAX) hits_in = hits_ff + COUNT_BITS'(1);
            end else if (misses_ff != COUNT_MAX) begin
               misses_in = misses_ff + COUNT_BITS'(1);
            end
         end
         MODE_PUT: begin
            if (hit_ff) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_ff[i] && (age_ff[i] < hit_age_ff)) begin
                     age_in[i] = age_ff[i] + AGE_W'(1);
                  end
               end
               age_in[hit_slot_ff] = '0;
               mem_wr = 1'b1;
            end else begin
               if (evict_ff) begin
                  valid_in[old_slot_ff] = 1'b0;
                  age_in[old_slot_ff]   = '0;
                  occ_in                = occ_in - OCC_W'(1);
               end
               if (ins_ok_ff) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_in[i]) age_in[i] = age_in[i] + AGE_W'(1);
                  end
                  valid_in[ins_slot_ff] = 1'b1;
                  age_in[ins_slot_ff]   = '0;
                  occ_in                = occ_in + OCC_W'(1);
                  key_wr                = 1'b1;
                  mem_wr                = 1'b1;
                  mem_addr              = ins_slot_ff;
               end
            end
         end
         MODE_CLEAR: begin
            valid_in  = '0;
            for (int i = 0; i < ENTRIES; i++) age_in[i] = '0;
            occ_in    = '0;
            hits_in   = '0;
            misses_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Control state of the entries
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         for (int i = 0; i < ENTRIES; i++) age_ff[i] <= '0;
         occ_ff    <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff  <= valid_in;
         age_ff    <= age_in;
         occ_ff    <= occ_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
      end
   end

   // Key registers
   always_ff @(posedge clock) begin
      if (cmd.commit && key_wr) begin
         keys_ff[ins_slot_ff] <= key_ff;
      end
   end

   // Value memory: read during lookup, written during update
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         rd_data_ff <= mem_values[hit_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && mem_wr) begin
         mem_values[mem_addr] <= value_ff;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff        <= hit_ff && ((mode_ff == MODE_GET) || (mode_ff == MODE_PUT));
         rsp_read_value_ff <= (hit_ff && (mode_ff == MODE_GET)) ? rd_data_ff : '0;
         rsp_evicted_ff    <= evict_ff && !hit_ff && (mode_ff == MODE_PUT);
         rsp_hit_total_ff  <= hits_in;
         rsp_miss_total_ff <= misses_in;
      end
   end

   assign status.rsp_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;
   assign rsp_hit_total  = rsp_hit_total_ff;
   assign rsp_miss_total = rsp_miss_total_ff;

endmodule

`default_nettype wire

[hdl/lru_key_value_cache.sv]
// Fully associative LRU key/value cache, ENTRIES register entries.
// An item is captured, looked up (key compare) and then committed (age/entry
// update) into the result register; a new item is taken only as one commits.
// A stalled result holds the next item in its update cycle until taken.
// Reset (synchronous): entries invalid, ages, occupancy and counters zero,
// capacity 16; keys and values are not cleared and no clearing pass runs.
`default_nettype none

module lru_key_value_cache
   import lkv_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_mode,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [VALUE_BITS-1:0] req_value,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_hit,
   output logic [VALUE_BITS-1:0]      rsp_read_value,
   output logic                       rsp_evicted,
   output logic [COUNT_BITS-1:0]      rsp_hit_total,
   output logic [COUNT_BITS-1:0]      rsp_miss_total,
   // register port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [2:0]            paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   lkv_cmd_type          cmd;
   lkv_status_type       status;
   logic [CAP_BITS-1:0]  capacity_ff;

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == CSR_CAPACITY)) begin
         capacity_ff <= pwdata[CAP_BITS-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_CAPACITY) ? 32'(capacity_ff) : '0;

   lkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lkv_datapath #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_mode),
      .req_key        (req_key),
      .req_value      (req_value),
      .capacity       (capacity_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .rsp_evicted    (rsp_evicted),
      .rsp_hit_total  (rsp_hit_total),
      .rsp_miss_total (rsp_miss_total)
   );

endmodule

`default_nettype wire

[hdl/lkv_checker.sv]
// Port-level checks for the LRU key/value cache, bound to the top level.
// Depends on lkv_pkg and lru_key_value_cache.
`default_nettype none

module lkv_checker
   import lkv_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic                  rsp_hit,
   input wire logic [VALUE_BITS-1:0] rsp_read_value,
   input wire logic                  rsp_evicted,
   input wire logic [COUNT_BITS-1:0] rsp_hit_total
);

   // No result pending straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One item at a time: the block is busy in the cycle after taking an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item taken during lookup");

   // An eviction only happens on a missed put, which returns no data
   a_evict_is_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> (!rsp_hit && (rsp_read_value == '0)))
      else $error("eviction reported with a hit or data");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_read_value) && $stable(rsp_hit_total)))
      else $error("stalled result changed");

endmodule

bind lru_key_value_cache lkv_checker #(
   .VALUE_BITS (VALUE_BITS)
) u_lkv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hit        (rsp_hit),
   .rsp_read_value (rsp_read_value),
   .rsp_evicted    (rsp_evicted),
   .rsp_hit_total  (rsp_hit_total)
);

`default_nettype wire
